/* design/hst_pkg.sv */
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and constants for the hashed span timeline core: hash
// constants, sequencer states, item and status structures.
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int ACC_W   = 86;
    localparam int FRAC_W  = 53;

    localparam logic [63:0] KEY_MUL  = 64'hD1B54A32D192ED03;
    localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;

    localparam logic [FRAC_W-1:0] ROUND_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

    localparam logic [1:0] FLD_ON    = 2'd0;
    localparam logic [1:0] FLD_OFF   = 2'd1;
    localparam logic [1:0] FLD_DELAY = 2'd2;
    localparam logic [1:0] FLD_END   = 2'd3;

    localparam logic [1:0] REG_KEY_CODE_ON    = 2'd0;
    localparam logic [1:0] REG_KEY_CODE_OFF   = 2'd1;
    localparam logic [1:0] REG_KEY_CODE_DELAY = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PICK,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_XS1,
        ST_MA0,
        ST_MA1,
        ST_MA2,
        ST_MA3,
        ST_XS2,
        ST_FRAC,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_DONE
    } hst_state_t;

    typedef struct packed {
        logic [31:0]      seed;
        logic [31:0]      epoch;
        logic [15:0]      inst;
        logic [15:0]      seg;
        logic [2:0]       mask;
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
    } hst_item_t;

    typedef struct packed {
        logic idle;
        logic done;
    } hst_stat_t;

endpackage

/* design/hashed_span_timeline_core.sv */
// A new word is taken only while the sequencer is idle, once the last word
//   has been handed over to the result register.
// Each ranged draw is ten passes through one shared 32x32 multiplier.
// The result register frees the sequencer as soon as a word is handed over.
// Reset (aresetn low, synchronous): position 0, key codes 1, 2, 4, no word held.
// ----------------------------------------------------------------------------
// hashed_span_timeline_core
// Counter-based random span timeline: hashed on/off/delay draws and a
// running 48-bit start position.
// ----------------------------------------------------------------------------
module hashed_span_timeline_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_restart,
    input  logic [31:0] s_seed,
    input  logic [31:0] s_epoch,
    input  logic [15:0] s_instance_req,
    input  logic [15:0] s_segment_index,
    input  logic [2:0]  s_ranged_mask,
    input  logic [31:0] s_on_low,
    input  logic [31:0] s_on_high,
    input  logic [31:0] s_off_low,
    input  logic [31:0] s_off_high,
    input  logic [31:0] s_delay_low,
    input  logic [31:0] s_delay_high,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_span_start,
    output logic [31:0] m_delay_count,
    output logic [31:0] m_on_count,
    output logic [31:0] m_off_count
);

    logic [7:0]          code_on_reg, code_on_next;
    logic [7:0]          code_off_reg, code_off_next;
    logic [7:0]          code_delay_reg, code_delay_next;
    logic [47:0]         position_reg, position_next;
    logic                restart_reg, restart_next;
    logic                m_valid_reg, m_valid_next;
    logic [47:0]         span_reg, span_next;
    logic [2:0][31:0]    out_cnt_reg, out_cnt_next;

    hst_pkg::hst_item_t  item;
    hst_pkg::hst_stat_t  stat;
    logic [2:0][7:0]     key_code;
    logic [2:0][31:0]    counts;
    logic                accept;
    logic                out_free;
    logic                handoff;
    logic [47:0]         base;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign handoff  = stat.done && out_free;
    assign s_ready  = stat.idle;

    assign item.seed  = s_seed;
    assign item.epoch = s_epoch;
    assign item.inst  = s_instance_req;
    assign item.seg   = s_segment_index;
    assign item.mask  = s_ranged_mask;
    assign item.lo    = {s_delay_low, s_off_low, s_on_low};
    assign item.hi    = {s_delay_high, s_off_high, s_on_high};
    assign key_code   = {code_delay_reg, code_off_reg, code_on_reg};

    hst_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .item     (item),
        .key_code (key_code),
        .done_ack (out_free),
        .stat     (stat),
        .counts   (counts)
    );

    assign base = restart_reg ? 48'h0 : position_reg;

    always_comb begin
        code_on_next    = code_on_reg;
        code_off_next   = code_off_reg;
        code_delay_next = code_delay_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                hst_pkg::REG_KEY_CODE_ON:    code_on_next    = cfg_wdata;
                hst_pkg::REG_KEY_CODE_OFF:   code_off_next   = cfg_wdata;
                hst_pkg::REG_KEY_CODE_DELAY: code_delay_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        restart_next  = accept ? s_restart : restart_reg;
        position_next = position_reg;
        m_valid_next  = m_valid_reg;
        span_next     = span_reg;
        out_cnt_next  = out_cnt_reg;
        if (handoff) begin
            // hand the word over and advance the position
            span_next     = base;
            out_cnt_next  = counts;
            position_next = base + 48'(counts[0]) + 48'(counts[1]) + 48'(counts[2]);
            m_valid_next  = 1'b1;
        end else if (m_ready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_on_reg    <= 8'd1;
            code_off_reg   <= 8'd2;
            code_delay_reg <= 8'd4;
            position_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            code_on_reg    <= code_on_next;
            code_off_reg   <= code_off_next;
            code_delay_reg <= code_delay_next;
            position_reg   <= position_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        restart_reg <= restart_next;
        span_reg    <= span_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_span_start  = span_reg;
    assign m_on_count    = out_cnt_reg[0];
    assign m_off_count   = out_cnt_reg[1];
    assign m_delay_count = out_cnt_reg[2];

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken again right after accept");

    a_handoff_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        handoff |=> m_valid && (m_span_start == $past(base)))
        else $error("finished word not presented");

    a_restart_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (handoff && restart_reg) |=> (m_span_start == 48'h0))
        else $error("restart span does not start at zero");

    a_no_handoff_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> !s_ready)
        else $error("sequencer done while accepting input");

endmodule

/* design/hst_mul.sv */
// ----------------------------------------------------------------------------
// hst_mul
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module hst_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = {32'h0, op_a} * {32'h0, op_b};

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* design/hst_seq.sv */
// ----------------------------------------------------------------------------
// hst_seq
// Draw sequencer: for each ranged count, builds the key, runs the
// splitmix64 mix and scales the fraction between low and high on the shared
// multiplier. Unranged counts take their low bound.
// ----------------------------------------------------------------------------
module hst_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  hst_pkg::hst_item_t     item,
    input  logic [2:0][7:0]        key_code,
    input  logic                   done_ack,
    output hst_pkg::hst_stat_t     stat,
    output logic [2:0][31:0]       counts
);

    hst_pkg::hst_state_t            state_reg, state_next;
    hst_pkg::hst_item_t             item_reg, item_next;
    logic [1:0]                     f_reg, f_next;
    logic                           mix_sel_reg, mix_sel_next;
    logic [63:0]                    val_reg, val_next;
    logic [hst_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic [31:0]                    d_reg, d_next;
    logic                           down_reg, down_next;
    logic [2:0][31:0]               cnt_reg, cnt_next;

    logic [31:0]                    op_a;
    logic [31:0]                    op_b;
    logic [63:0]                    prod;
    logic [63:0]                    mix_c;
    logic [31:0]                    lo_sel;
    logic [31:0]                    hi_sel;
    logic [7:0]                     code_sel;
    logic [63:0]                    key;
    logic [63:0]                    fin;
    logic [hst_pkg::FRAC_W-1:0]     round_add;
    logic [31:0]                    quot;

    hst_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb begin
        case (f_reg)
            hst_pkg::FLD_ON: begin
                lo_sel   = item_reg.lo[0];
                hi_sel   = item_reg.hi[0];
                code_sel = key_code[0];
            end
            hst_pkg::FLD_OFF: begin
                lo_sel   = item_reg.lo[1];
                hi_sel   = item_reg.hi[1];
                code_sel = key_code[1];
            end
            hst_pkg::FLD_DELAY: begin
                lo_sel   = item_reg.lo[2];
                hi_sel   = item_reg.hi[2];
                code_sel = key_code[2];
            end
            default: begin
                lo_sel   = '0;
                hi_sel   = '0;
                code_sel = '0;
            end
        endcase
    end

    assign mix_c     = mix_sel_reg ? hst_pkg::MIX_MUL2 : hst_pkg::MIX_MUL1;
    assign key       = acc_reg[63:0]
                       ^ {item_reg.epoch, 32'h0}
                       ^ {item_reg.inst, 48'h0}
                       ^ {8'h0, item_reg.seg, 40'h0}
                       ^ {48'h0, code_sel, 8'h0};
    assign fin       = acc_reg[63:0] ^ (acc_reg[63:0] >> 31);
    assign round_add = down_reg ? (hst_pkg::ROUND_HALF - 53'd1) : hst_pkg::ROUND_HALF;
    assign quot      = acc_reg[84:53];

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        f_next       = f_reg;
        mix_sel_next = mix_sel_reg;
        val_next     = val_reg;
        acc_next     = acc_reg;
        d_next       = d_reg;
        down_next    = down_reg;
        cnt_next     = cnt_reg;
        op_a         = '0;
        op_b         = '0;
        stat.idle    = 1'b0;
        stat.done    = 1'b0;

        case (state_reg)
            hst_pkg::ST_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    item_next  = item;
                    f_next     = hst_pkg::FLD_ON;
                    state_next = hst_pkg::ST_PICK;
                end
            end
            hst_pkg::ST_PICK: begin
                if (f_reg == hst_pkg::FLD_END) begin
                    state_next = hst_pkg::ST_DONE;
                end else if (item_reg.mask[f_reg]) begin
                    down_next  = (hi_sel < lo_sel);
                    d_next     = (hi_sel < lo_sel) ? (lo_sel - hi_sel) : (hi_sel - lo_sel);
                    state_next = hst_pkg::ST_K0;
                end else begin
                    cnt_next[f_reg] = lo_sel;
                    f_next          = f_reg + 2'd1;
                end
            end
            hst_pkg::ST_K0: begin
                op_a       = item_reg.seed;
                op_b       = hst_pkg::KEY_MUL[31:0];
                state_next = hst_pkg::ST_K1;
            end
            hst_pkg::ST_K1: begin
                op_a       = item_reg.seed;
                op_b       = hst_pkg::KEY_MUL[63:32];
                acc_next   = hst_pkg::ACC_W'(prod);
                state_next = hst_pkg::ST_K2;
            end
            hst_pkg::ST_K2: begin
                acc_next   = hst_pkg::ACC_W'(acc_reg[63:0] + {prod[31:0], 32'h0});
                state_next = hst_pkg::ST_K3;
            end
            hst_pkg::ST_K3: begin
                val_next   = key + hst_pkg::GOLDEN;
                state_next = hst_pkg::ST_XS1;
            end
            hst_pkg::ST_XS1: begin
                val_next     = val_reg ^ (val_reg >> 30);
                mix_sel_next = 1'b0;
                state_next   = hst_pkg::ST_MA0;
            end
            hst_pkg::ST_MA0: begin
                op_a       = val_reg[31:0];
                op_b       = mix_c[31:0];
                state_next = hst_pkg::ST_MA1;
            end
            hst_pkg::ST_MA1: begin
                op_a       = val_reg[31:0];
                op_b       = mix_c[63:32];
                acc_next   = hst_pkg::ACC_W'(prod);
                state_next = hst_pkg::ST_MA2;
            end
            hst_pkg::ST_MA2: begin
                op_a       = val_reg[63:32];
                op_b       = mix_c[31:0];
                acc_next   = hst_pkg::ACC_W'(acc_reg[63:0] + {prod[31:0], 32'h0});
                state_next = hst_pkg::ST_MA3;
            end
            hst_pkg::ST_MA3: begin
                acc_next   = hst_pkg::ACC_W'(acc_reg[63:0] + {prod[31:0], 32'h0});
                state_next = mix_sel_reg ? hst_pkg::ST_FRAC : hst_pkg::ST_XS2;
            end
            hst_pkg::ST_XS2: begin
                val_next     = acc_reg[63:0] ^ (acc_reg[63:0] >> 27);
                mix_sel_next = 1'b1;
                state_next   = hst_pkg::ST_MA0;
            end
            hst_pkg::ST_FRAC: begin
                val_next   = {11'h0, fin[63:11]};
                state_next = hst_pkg::ST_P0;
            end
            hst_pkg::ST_P0: begin
                op_a       = d_reg;
                op_b       = val_reg[31:0];
                state_next = hst_pkg::ST_P1;
            end
            hst_pkg::ST_P1: begin
                op_a       = d_reg;
                op_b       = {11'h0, val_reg[52:32]};
                acc_next   = hst_pkg::ACC_W'(prod) + hst_pkg::ACC_W'(round_add);
                state_next = hst_pkg::ST_P2;
            end
            hst_pkg::ST_P2: begin
                acc_next   = acc_reg + {prod[53:0], 32'h0};
                state_next = hst_pkg::ST_P3;
            end
            hst_pkg::ST_P3: begin
                cnt_next[f_reg] = down_reg ? (lo_sel - quot) : (lo_sel + quot);
                f_next          = f_reg + 2'd1;
                state_next      = hst_pkg::ST_PICK;
            end
            hst_pkg::ST_DONE: begin
                stat.done = 1'b1;
                if (done_ack) begin
                    state_next = hst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hst_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        f_reg       <= f_next;
        mix_sel_reg <= mix_sel_next;
        val_reg     <= val_next;
        acc_reg     <= acc_next;
        d_reg       <= d_next;
        down_reg    <= down_next;
        cnt_reg     <= cnt_next;
    end

    assign counts = cnt_reg;

endmodule
